FILE: rtl/core/tlb_pkg.sv
package tlb_pkg;

  localparam logic [15:0] CODE_NEWLINE    = 16'd10;
  localparam logic [15:0] CODE_SPACE      = 16'd32;
  localparam logic [15:0] CODE_NARROW_MAX = 16'h00ff;
  localparam logic [23:0] WIDTH_MAX       = 24'hffffff;

  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic REG_CELL_WIDTH  = 1'b0;
  localparam logic REG_WRAP_ENABLE = 1'b1;

  typedef struct packed {
    logic        last_line;
    logic [23:0] line_width;
    logic [15:0] line_length;
    logic [15:0] line_begin;
  } line_desc_t;

  // all lines produced by one character, slot 0 first
  typedef struct packed {
    logic [1:0]                        cnt;
    line_desc_t [MAX_RESULTS-1:0]      line;
  } line_group_t;

  typedef struct packed {
    logic        we;
    logic        index;
    logic [15:0] data;
  } cfg_wr_t;

  function automatic logic [23:0] add_width(input logic [23:0] a, input logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? WIDTH_MAX : s[23:0];
  endfunction

endpackage

FILE: rtl/core/tlb_front.sv
module tlb_front #(
  parameter int MAX_TEXT_LEN = 65535
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlb_pkg::cfg_wr_t     cfg,
  input  logic                 in_valid,
  input  logic [15:0]          char_code,
  input  logic [7:0]           char_width,
  input  logic                 last_char,
  input  logic                 q_full,
  output logic                 in_ready,
  output logic                 q_push,
  output tlb_pkg::line_group_t q_data
);

  localparam int CW = $clog2(MAX_TEXT_LEN + 1);
  localparam logic [CW:0] MaxCnt = (CW + 1)'(MAX_TEXT_LEN);

  function automatic logic [CW-1:0] add_cnt(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > MaxCnt) ? MaxCnt[CW-1:0] : s[CW-1:0];
  endfunction

  logic [15:0] cell_width_r;
  logic        wrap_enable_r;

  logic [CW-1:0] char_pos_r, word_begin_r, word_count_r, line_start_r, line_count_r;
  logic [23:0]   word_total_r, word_visible_r, line_total_r;
  logic          word_nl_r, space_seen_r;

  logic [CW-1:0] char_pos_nxt, word_begin_nxt, word_count_nxt, line_start_nxt, line_count_nxt;
  logic [23:0]   word_total_nxt, word_visible_nxt, line_total_nxt;
  logic          word_nl_nxt, space_seen_nxt;
  tlb_pkg::line_group_t grp;

  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (grp.cnt != 2'd0);
  assign q_data   = grp;

  always_comb begin
    logic brk;
    logic close_word;
    char_pos_nxt     = char_pos_r;
    word_begin_nxt   = word_begin_r;
    word_count_nxt   = word_count_r;
    word_total_nxt   = word_total_r;
    word_visible_nxt = word_visible_r;
    word_nl_nxt      = word_nl_r;
    space_seen_nxt   = space_seen_r;
    line_start_nxt   = line_start_r;
    line_count_nxt   = line_count_r;
    line_total_nxt   = line_total_r;
    grp              = '0;
    brk              = 1'b0;
    close_word       = 1'b0;

    if (wrap_enable_r) begin
      close_word = (word_count_r != '0) &&
                   ((space_seen_r && char_code != tlb_pkg::CODE_SPACE) ||
                    (({1'b0, word_total_r} + 25'(char_width)) > 25'(cell_width_r)) ||
                    (char_code > tlb_pkg::CODE_NARROW_MAX) ||
                    (char_code == tlb_pkg::CODE_NEWLINE));
      // pack the open word before this character
      if (close_word) begin
        brk = word_nl_nxt || ((line_count_nxt != '0) &&
              (({1'b0, line_total_nxt} + {1'b0, word_visible_nxt}) > 25'(cell_width_r)));
        if (brk) begin
          grp.line[grp.cnt] = '{last_line: 1'b0, line_width: line_total_nxt,
                                line_length: 16'(line_count_nxt),
                                line_begin: 16'(line_start_nxt)};
          grp.cnt        = grp.cnt + 2'd1;
          line_start_nxt = word_begin_nxt;
          line_count_nxt = '0;
          line_total_nxt = '0;
        end
        line_count_nxt   = add_cnt(line_count_nxt, word_count_nxt);
        line_total_nxt   = tlb_pkg::add_width(line_total_nxt, word_total_nxt);
        word_count_nxt   = '0;
        word_total_nxt   = '0;
        word_visible_nxt = '0;
        word_nl_nxt      = 1'b0;
        space_seen_nxt   = 1'b0;
      end
      if (word_count_nxt == '0) begin
        word_begin_nxt = char_pos_r;
        word_nl_nxt    = (char_code == tlb_pkg::CODE_NEWLINE);
      end
      word_count_nxt = add_cnt(word_count_nxt, CW'(1));
      word_total_nxt = tlb_pkg::add_width(word_total_nxt, 24'(char_width));
      if (char_code == tlb_pkg::CODE_SPACE) begin
        space_seen_nxt = 1'b1;
      end else begin
        word_visible_nxt = tlb_pkg::add_width(word_visible_nxt, 24'(char_width));
      end
      // end of text: pack the word just grown
      if (last_char) begin
        brk = word_nl_nxt || ((line_count_nxt != '0) &&
              (({1'b0, line_total_nxt} + {1'b0, word_visible_nxt}) > 25'(cell_width_r)));
        if (brk) begin
          grp.line[grp.cnt] = '{last_line: 1'b0, line_width: line_total_nxt,
                                line_length: 16'(line_count_nxt),
                                line_begin: 16'(line_start_nxt)};
          grp.cnt        = grp.cnt + 2'd1;
          line_start_nxt = word_begin_nxt;
          line_count_nxt = '0;
          line_total_nxt = '0;
        end
        line_count_nxt = add_cnt(line_count_nxt, word_count_nxt);
        line_total_nxt = tlb_pkg::add_width(line_total_nxt, word_total_nxt);
      end
    end else begin
      // merge a word left open by wrap mode
      if (word_count_r != '0) begin
        line_count_nxt   = add_cnt(line_count_nxt, word_count_r);
        line_total_nxt   = tlb_pkg::add_width(line_total_nxt, word_total_r);
        word_count_nxt   = '0;
        word_total_nxt   = '0;
        word_visible_nxt = '0;
        word_nl_nxt      = 1'b0;
        space_seen_nxt   = 1'b0;
      end
      if (char_code == tlb_pkg::CODE_NEWLINE) begin
        grp.line[grp.cnt] = '{last_line: 1'b0, line_width: line_total_nxt,
                              line_length: 16'(line_count_nxt),
                              line_begin: 16'(line_start_nxt)};
        grp.cnt        = grp.cnt + 2'd1;
        line_start_nxt = add_cnt(char_pos_r, CW'(1));
        line_count_nxt = '0;
        line_total_nxt = '0;
      end else begin
        line_count_nxt = add_cnt(line_count_nxt, CW'(1));
        line_total_nxt = tlb_pkg::add_width(line_total_nxt, 24'(char_width));
      end
    end

    char_pos_nxt = add_cnt(char_pos_r, CW'(1));

    if (last_char) begin
      grp.line[grp.cnt] = '{last_line: 1'b1, line_width: line_total_nxt,
                            line_length: 16'(line_count_nxt),
                            line_begin: 16'(line_start_nxt)};
      grp.cnt          = grp.cnt + 2'd1;
      char_pos_nxt     = '0;
      word_begin_nxt   = '0;
      word_count_nxt   = '0;
      word_total_nxt   = '0;
      word_visible_nxt = '0;
      word_nl_nxt      = 1'b0;
      space_seen_nxt   = 1'b0;
      line_start_nxt   = '0;
      line_count_nxt   = '0;
      line_total_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= '0;
      wrap_enable_r <= 1'b0;
    end else if (cfg.we) begin
      case (cfg.index)
        tlb_pkg::REG_CELL_WIDTH:  cell_width_r  <= cfg.data;
        tlb_pkg::REG_WRAP_ENABLE: wrap_enable_r <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_pos_r     <= '0;
      word_begin_r   <= '0;
      word_count_r   <= '0;
      word_total_r   <= '0;
      word_visible_r <= '0;
      word_nl_r      <= 1'b0;
      space_seen_r   <= 1'b0;
      line_start_r   <= '0;
      line_count_r   <= '0;
      line_total_r   <= '0;
    end else if (accept) begin
      char_pos_r     <= char_pos_nxt;
      word_begin_r   <= word_begin_nxt;
      word_count_r   <= word_count_nxt;
      word_total_r   <= word_total_nxt;
      word_visible_r <= word_visible_nxt;
      word_nl_r      <= word_nl_nxt;
      space_seen_r   <= space_seen_nxt;
      line_start_r   <= line_start_nxt;
      line_count_r   <= line_count_nxt;
      line_total_r   <= line_total_nxt;
    end
  end

endmodule

FILE: rtl/core/tlb_queue.sv
module tlb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tlb_pkg::line_group_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output tlb_pkg::line_group_t pop_data
);

  localparam int AW = $clog2(tlb_pkg::QUEUE_DEPTH);
  localparam logic [AW:0] Depth = (AW + 1)'(tlb_pkg::QUEUE_DEPTH);

  tlb_pkg::line_group_t slot_r [tlb_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(tlb_pkg::QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full      = (count_r == Depth);
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      count_r <= count_r + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

FILE: rtl/core/tlb_back.sv
module tlb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  tlb_pkg::line_group_t q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlb_pkg::line_desc_t  out_line
);

  tlb_pkg::line_group_t cur_r;
  logic [1:0]           idx_r;
  logic                 valid_r;
  logic                 fire, done;

  assign out_valid = valid_r;
  assign out_line  = cur_r.line[idx_r];
  assign fire      = valid_r && out_ready;
  assign done      = fire && (idx_r == cur_r.cnt - 2'd1);
  assign q_pop     = q_not_empty && (!valid_r || done);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (done) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

FILE: rtl/core/text_line_breaker.sv
// Channel  Dir  Handshake                  Payload
// in_      in   in_tvalid / in_tready      char_code, char_width; last_char on in_tlast
// out_     out  out_tvalid / out_tready    line_begin, line_length, line_width;
//                                          last_line on out_tlast
// cfg_     in   cfg_we (no wait)           cell_width (index 0), wrap_enable (index 1)
//
// One character request per cycle. The front updates the word and line state in the
// cycle of acceptance and hands zero to three line descriptors to a two-entry queue.
// The back sends one descriptor per cycle while out_tready is high, so the sustained
// rate is one character a cycle while each character yields at most one line.
// Reset (rst_n low, synchronous) clears the text state, the registers, the queue and
// the output stage. in_tready drops only while the queue is full; out_tready low
// holds the current descriptor and lets the front keep filling the queue.
module text_line_breaker #(
  parameter int MAX_TEXT_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // character requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] char_code, [23:16] char_width
  input  logic        in_tlast,   // last_char
  // line descriptors
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] line_begin, [31:16] line_length, [55:32] line_width
  output logic        out_tlast   // last_line
);

  tlb_pkg::cfg_wr_t     cfg;
  tlb_pkg::line_group_t push_data, pop_data;
  tlb_pkg::line_desc_t  line;
  logic                 push, pop, q_full, q_not_empty;

  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_wdata};

  // front: classify characters, track words and lines
  tlb_front #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .char_code (in_tdata[15:0]),
    .char_width(in_tdata[23:16]),
    .last_char (in_tlast),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .q_push    (push),
    .q_data    (push_data)
  );

  // decouple the two sides
  tlb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .pop_data (pop_data)
  );

  // back: drain each group one line at a time
  tlb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_data     (pop_data),
    .q_pop      (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_line   (line)
  );

  assign out_tdata = {line.line_width, line.line_length, line.line_begin};
  assign out_tlast = line.last_line;

endmodule

FILE: rtl/core/tlb_checker.sv
module tlb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  // a stalled descriptor stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled line descriptor changed");

  // reset empties queue and output stage
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("reset left pending lines");

  // a full queue means the back already holds a group
  a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("queue full while output idle");

endmodule

bind text_line_breaker tlb_checker u_tlb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
